/* rtl/core/tcsad_pkg.sv */
// Package for the Type-C source attach detector.
// Holds CC class codes, register index codes and the structs shared by the core and the top level.
// No dependencies.
package tcsad_pkg;

   localparam logic [2:0] CLS_NONE = 3'b000;
   localparam logic [2:0] CLS_RA   = 3'b001;
   localparam logic [2:0] CLS_RD   = 3'b010;
   localparam logic [2:0] CLS_OPEN = 3'b100;

   localparam int CLS_RA_BIT   = 0;
   localparam int CLS_RD_BIT   = 1;
   localparam int CLS_OPEN_BIT = 2;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int COUNT_WIDTH     = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_THRESHOLD_HIGH    = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_THRESHOLD_LOW     = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CC_DEBOUNCE       = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PD_DEBOUNCE       = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SLEEP_DELAY       = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SLEEP_ENABLE      = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ATTACHED_CC_SENSE = 3'd6;

   localparam logic [COUNT_WIDTH-1:0] CC_DEBOUNCE_RESET = 16'd150;
   localparam logic [COUNT_WIDTH-1:0] PD_DEBOUNCE_RESET = 16'd15;
   localparam logic [COUNT_WIDTH-1:0] SLEEP_DELAY_RESET = 16'd1000;

   localparam logic OP_TICK = 1'b0;

   typedef struct packed {
      logic [7:0]             threshold_high;
      logic [7:0]             threshold_low;
      logic [COUNT_WIDTH-1:0] cc_debounce_ticks;
      logic [COUNT_WIDTH-1:0] pd_debounce_ticks;
      logic [COUNT_WIDTH-1:0] sleep_delay_ticks;
      logic                   sleep_enable;
      logic                   attached_cc_sense;
   } cfg_type;

   typedef struct packed {
      logic       op;
      logic [7:0] cc1_level;
      logic [7:0] cc2_level;
      logic       error_recovery;
   } item_type;

   typedef struct packed {
      logic       is_attached;
      logic       is_flipped;
      logic       ra_seen;
      logic       is_sleeping;
      logic [2:0] cc1_class;
      logic [2:0] cc2_class;
      logic       attach_event;
      logic       detach_event;
      logic       sleep_event;
      logic       wake_event;
   } result_type;

endpackage

/* rtl/core/tcsad_classify.sv */
// CC level classifier: sorts one sampled level into a one-hot Ra / Rd / open class.
// Depends on tcsad_pkg for the class codes.
module tcsad_classify
   import tcsad_pkg::*;
(
   input  logic [7:0] level,
   input  logic [7:0] threshold_high,
   input  logic [7:0] threshold_low,
   output logic [2:0] cc_class
);

   always_comb begin
      if (level >= threshold_high) begin
         cc_class = CLS_OPEN;
      end else if (level >= threshold_low) begin
         cc_class = CLS_RD;
      end else begin
         cc_class = CLS_RA;
      end
   end

endmodule

/* rtl/core/tcsad_core.sv */
// Attach / detach state and single-pass update for one transaction.
// Depends on tcsad_pkg and tcsad_classify.
module tcsad_core
   import tcsad_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  item_type   item,
   input  cfg_type    cfg,
   output result_type result
);

   logic [2:0]             cc1_status_ff, cc1_status_in;
   logic [2:0]             cc2_status_ff, cc2_status_in;
   logic                   attached_ff, attached_in;
   logic                   sleeping_ff, sleeping_in;
   logic                   debouncing_ff, debouncing_in;
   logic                   ra_flag_ff, ra_flag_in;
   logic                   flipped_ff, flipped_in;
   logic [COUNT_WIDTH-1:0] countdown_ff, countdown_in;

   logic [2:0]             cls1, cls2;
   logic                   changed, one_rd, tick, err;
   logic [COUNT_WIDTH-1:0] count_loaded, count_dec;
   logic                   debounce_loaded;
   logic [2:0]             active;
   logic                   ev_att, ev_det, ev_slp, ev_wake;

   tcsad_classify u_cls1 (
      .level          (item.cc1_level),
      .threshold_high (cfg.threshold_high),
      .threshold_low  (cfg.threshold_low),
      .cc_class       (cls1)
   );

   tcsad_classify u_cls2 (
      .level          (item.cc2_level),
      .threshold_high (cfg.threshold_high),
      .threshold_low  (cfg.threshold_low),
      .cc_class       (cls2)
   );

   always_comb begin
      tick = (item.op == OP_TICK);
      err  = item.error_recovery;

      cc1_status_in = cls1;
      cc2_status_in = cls2;
      if (attached_ff) begin
         if (flipped_ff) begin
            cc1_status_in = cc1_status_ff;
            cc2_status_in = cfg.attached_cc_sense ? cls2 : CLS_RD;
         end else begin
            cc1_status_in = cfg.attached_cc_sense ? cls1 : CLS_RD;
            cc2_status_in = cc2_status_ff;
         end
      end

      changed = (cc1_status_in != cc1_status_ff) || (cc2_status_in != cc2_status_ff);
      one_rd  = cc1_status_in[CLS_RD_BIT] ^ cc2_status_in[CLS_RD_BIT];
      ev_wake = changed && sleeping_ff && one_rd;
      sleeping_in = sleeping_ff && !ev_wake;

      // restart debounce on a class change while awake
      count_loaded    = countdown_ff;
      debounce_loaded = debouncing_ff;
      if (changed && !sleeping_in) begin
         if (attached_ff) begin
            count_loaded = cfg.pd_debounce_ticks;
         end else begin
            count_loaded    = cfg.cc_debounce_ticks;
            debounce_loaded = 1'b1;
         end
      end

      count_dec     = count_loaded - COUNT_WIDTH'(1);
      countdown_in  = count_loaded;
      debouncing_in = debounce_loaded;
      attached_in   = attached_ff;
      ra_flag_in    = ra_flag_ff;
      flipped_in    = flipped_ff;
      active        = flipped_ff ? cc2_status_in : cc1_status_in;
      ev_att        = 1'b0;
      ev_det        = 1'b0;
      ev_slp        = 1'b0;

      if (tick && (count_loaded != '0)) begin
         countdown_in = count_dec;
         if (count_dec == '0) begin
            if (attached_ff) begin
               if (active[CLS_OPEN_BIT] || err) begin
                  attached_in = 1'b0;
                  ra_flag_in  = 1'b0;
                  ev_det      = 1'b1;
                  if (cfg.sleep_enable && !err) begin
                     countdown_in = cfg.sleep_delay_ticks;
                  end
               end
            end else if (debounce_loaded) begin
               debouncing_in = 1'b0;
               if (one_rd) begin
                  attached_in = 1'b1;
                  ra_flag_in  = cc1_status_in[CLS_RA_BIT] | cc2_status_in[CLS_RA_BIT];
                  flipped_in  = !cc1_status_in[CLS_RD_BIT];
                  ev_att      = 1'b1;
               end else if (cfg.sleep_enable && !err) begin
                  countdown_in = cfg.sleep_delay_ticks;
               end
            end else begin
               sleeping_in = 1'b1;
               ev_slp      = 1'b1;
            end
         end
      end

      result.is_attached  = attached_in;
      result.is_flipped   = flipped_in;
      result.ra_seen      = ra_flag_in;
      result.is_sleeping  = sleeping_in;
      result.cc1_class    = cc1_status_in;
      result.cc2_class    = cc2_status_in;
      result.attach_event = ev_att;
      result.detach_event = ev_det;
      result.sleep_event  = ev_slp;
      result.wake_event   = ev_wake;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cc1_status_ff <= CLS_NONE;
         cc2_status_ff <= CLS_NONE;
         attached_ff   <= 1'b0;
         sleeping_ff   <= 1'b0;
         debouncing_ff <= 1'b0;
         ra_flag_ff    <= 1'b0;
         flipped_ff    <= 1'b0;
         countdown_ff  <= '0;
      end else if (advance) begin
         cc1_status_ff <= cc1_status_in;
         cc2_status_ff <= cc2_status_in;
         attached_ff   <= attached_in;
         sleeping_ff   <= sleeping_in;
         debouncing_ff <= debouncing_in;
         ra_flag_ff    <= ra_flag_in;
         flipped_ff    <= flipped_in;
         countdown_ff  <= countdown_in;
      end
   end

endmodule

/* rtl/core/typec_source_attach_detect_top.sv */
// Top level of the Type-C source CC attach / detach detector.
// Depends on tcsad_pkg and tcsad_core.
//
// Usage:
//   req_ channel: one transaction per millisecond tick (op 0) or sleep-mode
//   sample (op 1), carrying both CC levels and the error recovery flag.
//   rsp_ channel: one transaction per request with the attach, flip, Ra and
//   sleep status, both one-hot CC classes and the event flags of that request.
//   csr_ port: write enable, register index and data; the write is registered.
//   Write registers only while no transaction is in flight.
// Path: an accepted request is held in the input register; the update, one
//   combinational pass from the input register and the detector state, writes
//   its result into the response register.
// Throughput: one transaction per cycle while rsp_ready does not stall it.
// Reset: clears the detector state (no class, detached, awake, countdown idle)
//   and loads register defaults: thresholds 0, debounce 150 / 15, sleep delay
//   1000, sleep disabled, attached CC sensing on.
// Stall: while rsp_ready is low the response holds; one more request is taken
//   into the input register, then req_ready drops until the response leaves.
module typec_source_attach_detect_top
   import tcsad_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_op,
   input  logic [7:0]                 req_cc1_level,
   input  logic [7:0]                 req_cc2_level,
   input  logic                       req_error_recovery,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_is_attached,
   output logic                       rsp_is_flipped,
   output logic                       rsp_ra_seen,
   output logic                       rsp_is_sleeping,
   output logic [2:0]                 rsp_cc1_class,
   output logic [2:0]                 rsp_cc2_class,
   output logic                       rsp_attach_event,
   output logic                       rsp_detach_event,
   output logic                       rsp_sleep_event,
   output logic                       rsp_wake_event,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   cfg_type    cfg_ff, cfg_in;
   item_type   item_ff;
   logic       item_valid_ff;
   result_type result, result_ff;
   logic       rsp_valid_ff;
   logic       advance;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_THRESHOLD_HIGH:    cfg_in.threshold_high    = csr_write_data[7:0];
            CSR_THRESHOLD_LOW:     cfg_in.threshold_low     = csr_write_data[7:0];
            CSR_CC_DEBOUNCE:       cfg_in.cc_debounce_ticks = csr_write_data;
            CSR_PD_DEBOUNCE:       cfg_in.pd_debounce_ticks = csr_write_data;
            CSR_SLEEP_DELAY:       cfg_in.sleep_delay_ticks = csr_write_data;
            CSR_SLEEP_ENABLE:      cfg_in.sleep_enable      = csr_write_data[0];
            CSR_ATTACHED_CC_SENSE: cfg_in.attached_cc_sense = csr_write_data[0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold_high    <= '0;
         cfg_ff.threshold_low     <= '0;
         cfg_ff.cc_debounce_ticks <= CC_DEBOUNCE_RESET;
         cfg_ff.pd_debounce_ticks <= PD_DEBOUNCE_RESET;
         cfg_ff.sleep_delay_ticks <= SLEEP_DELAY_RESET;
         cfg_ff.sleep_enable      <= 1'b0;
         cfg_ff.attached_cc_sense <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign advance   = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req_ready) begin
            item_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.op             <= req_op;
         item_ff.cc1_level      <= req_cc1_level;
         item_ff.cc2_level      <= req_cc2_level;
         item_ff.error_recovery <= req_error_recovery;
      end
      if (advance) begin
         result_ff <= result;
      end
   end

   tcsad_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .cfg     (cfg_ff),
      .result  (result)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_is_attached  = result_ff.is_attached;
   assign rsp_is_flipped   = result_ff.is_flipped;
   assign rsp_ra_seen      = result_ff.ra_seen;
   assign rsp_is_sleeping  = result_ff.is_sleeping;
   assign rsp_cc1_class    = result_ff.cc1_class;
   assign rsp_cc2_class    = result_ff.cc2_class;
   assign rsp_attach_event = result_ff.attach_event;
   assign rsp_detach_event = result_ff.detach_event;
   assign rsp_sleep_event  = result_ff.sleep_event;
   assign rsp_wake_event   = result_ff.wake_event;

   a_class_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($onehot(rsp_cc1_class) && $onehot(rsp_cc2_class)))
      else $error("response CC class is not one-hot");

   a_attach_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_attach_event) |-> (rsp_is_attached && !rsp_detach_event))
      else $error("attach event without attached status");

   a_sleep_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_sleep_event) |-> (rsp_is_sleeping && !rsp_is_attached))
      else $error("sleep event while attached or awake");

   a_wake_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_wake_event) |-> !rsp_is_sleeping)
      else $error("wake event while still sleeping");

   a_in_flight: assert property (@(posedge clock) disable iff (reset)
      (item_valid_ff && !advance) |=> item_valid_ff)
      else $error("held transaction lost from input register");

endmodule

/* test/typec_source_attach_detect_top_tb.sv */
`timescale 1ns / 1ps
// Testbench for typec_source_attach_detect_top: directed and random CC transactions,
// each response checked against a cycle-free predictor of the attach detector kept here.
// Depends on tcsad_pkg and the RTL top level with its core.
module typec_source_attach_detect_top_tb;
   import tcsad_pkg::*;

   localparam logic OP_SAMPLE      = ~OP_TICK;
   localparam int   LATENCY_CYCLES = 4;

   logic                       clock              = 1'b0;
   logic                       reset              = 1'b1;
   logic                       req_valid          = 1'b0;
   logic                       req_ready;
   logic                       req_op             = OP_TICK;
   logic [7:0]                 req_cc1_level      = '0;
   logic [7:0]                 req_cc2_level      = '0;
   logic                       req_error_recovery = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready          = 1'b0;
   logic                       rsp_is_attached;
   logic                       rsp_is_flipped;
   logic                       rsp_ra_seen;
   logic                       rsp_is_sleeping;
   logic [2:0]                 rsp_cc1_class;
   logic [2:0]                 rsp_cc2_class;
   logic                       rsp_attach_event;
   logic                       rsp_detach_event;
   logic                       rsp_sleep_event;
   logic                       rsp_wake_event;
   logic                       csr_write_enable   = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index          = CSR_THRESHOLD_HIGH;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data     = '0;

   typec_source_attach_detect_top dut (.*);

   cfg_type     model_cfg;
   logic [2:0]  cc1_cls       = CLS_NONE;
   logic [2:0]  cc2_cls       = CLS_NONE;
   logic        link_attached = 1'b0;
   logic        link_sleeping = 1'b0;
   logic        cc_debouncing = 1'b0;
   logic        ra_found      = 1'b0;
   logic        cc2_active    = 1'b0;
   logic [15:0] ticks_left    = '0;

   result_type  expected_results[$];
   int          error_count      = 0;
   int          send_idle_pct    = 0;
   int          rsp_stall_pct    = 0;
   int          rsp_holdoff_left = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic cfg_type make_config(input logic [7:0] th_high, input logic [7:0] th_low,
                                           input logic [15:0] cc_ticks,
                                           input logic [15:0] pd_ticks,
                                           input logic [15:0] sleep_ticks,
                                           input logic sleep_en, input logic sense);
      cfg_type c;
      c.threshold_high    = th_high;
      c.threshold_low     = th_low;
      c.cc_debounce_ticks = cc_ticks;
      c.pd_debounce_ticks = pd_ticks;
      c.sleep_delay_ticks = sleep_ticks;
      c.sleep_enable      = sleep_en;
      c.attached_cc_sense = sense;
      return c;
   endfunction

   function automatic logic [2:0] classify_level(input logic [7:0] level);
      if (level >= model_cfg.threshold_high) return CLS_OPEN;
      if (level >= model_cfg.threshold_low) return CLS_RD;
      return CLS_RA;
   endfunction

   function automatic logic single_rd();
      return cc1_cls[CLS_RD_BIT] ^ cc2_cls[CLS_RD_BIT];
   endfunction

   function automatic void arm_sleep_timer(input logic err);
      if (model_cfg.sleep_enable && !err) ticks_left = model_cfg.sleep_delay_ticks;
   endfunction

   function automatic result_type detect_step(input item_type it);
      logic [2:0] prev1, prev2, active;
      result_type r;
      prev1 = cc1_cls;
      prev2 = cc2_cls;
      r = '0;
      if (link_attached) begin
         if (cc2_active)
            cc2_cls = model_cfg.attached_cc_sense ? classify_level(it.cc2_level) : CLS_RD;
         else
            cc1_cls = model_cfg.attached_cc_sense ? classify_level(it.cc1_level) : CLS_RD;
      end else begin
         cc1_cls = classify_level(it.cc1_level);
         cc2_cls = classify_level(it.cc2_level);
      end
      if (cc1_cls != prev1 || cc2_cls != prev2) begin
         if (link_sleeping && single_rd()) begin
            link_sleeping = 1'b0;
            r.wake_event = 1'b1;
         end
         if (!link_sleeping) begin
            if (link_attached) begin
               ticks_left = model_cfg.pd_debounce_ticks;
            end else begin
               ticks_left = model_cfg.cc_debounce_ticks;
               cc_debouncing = 1'b1;
            end
         end
      end
      if (it.op == OP_TICK && ticks_left != 0) begin
         ticks_left = ticks_left - 16'd1;
         if (ticks_left == 0) begin
            if (link_attached) begin
               active = cc2_active ? cc2_cls : cc1_cls;
               if (active[CLS_OPEN_BIT] || it.error_recovery) begin
                  link_attached = 1'b0;
                  ra_found = 1'b0;
                  r.detach_event = 1'b1;
                  arm_sleep_timer(it.error_recovery);
               end
            end else if (cc_debouncing) begin
               cc_debouncing = 1'b0;
               if (single_rd()) begin
                  link_attached = 1'b1;
                  ra_found = cc1_cls[CLS_RA_BIT] | cc2_cls[CLS_RA_BIT];
                  cc2_active = !cc1_cls[CLS_RD_BIT];
                  r.attach_event = 1'b1;
               end else begin
                  arm_sleep_timer(it.error_recovery);
               end
            end else begin
               link_sleeping = 1'b1;
               r.sleep_event = 1'b1;
            end
         end
      end
      r.is_attached = link_attached;
      r.is_flipped  = cc2_active;
      r.ra_seen     = ra_found;
      r.is_sleeping = link_sleeping;
      r.cc1_class   = cc1_cls;
      r.cc2_class   = cc2_cls;
      return r;
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         error_count++;
      end
   endfunction

   initial begin : response_checker
      result_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: response transaction with none outstanding", $time);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("is_attached", 32'(want.is_attached), 32'(rsp_is_attached));
               check_field("is_flipped", 32'(want.is_flipped), 32'(rsp_is_flipped));
               check_field("ra_seen", 32'(want.ra_seen), 32'(rsp_ra_seen));
               check_field("is_sleeping", 32'(want.is_sleeping), 32'(rsp_is_sleeping));
               check_field("cc1_class", 32'(want.cc1_class), 32'(rsp_cc1_class));
               check_field("cc2_class", 32'(want.cc2_class), 32'(rsp_cc2_class));
               check_field("attach_event", 32'(want.attach_event), 32'(rsp_attach_event));
               check_field("detach_event", 32'(want.detach_event), 32'(rsp_detach_event));
               check_field("sleep_event", 32'(want.sleep_event), 32'(rsp_sleep_event));
               check_field("wake_event", 32'(want.wake_event), 32'(rsp_wake_event));
            end
         end
         if (rsp_holdoff_left > 0) begin
            rsp_ready <= 1'b0;
            rsp_holdoff_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   task automatic send_item(input logic op, input logic [7:0] level1, input logic [7:0] level2,
                            input logic err);
      item_type it;
      it.op             = op;
      it.cc1_level      = level1;
      it.cc2_level      = level2;
      it.error_recovery = err;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_op             <= op;
      req_cc1_level      <= level1;
      req_cc2_level      <= level2;
      req_error_recovery <= err;
      do @(posedge clock); while (!req_ready);
      expected_results.push_back(detect_step(it));
   endtask

   task automatic wait_for_responses();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (LATENCY_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] index,
                                 input logic [CSR_DATA_WIDTH-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
   endtask

   task automatic load_config(input cfg_type c);
      write_register(CSR_THRESHOLD_HIGH, {8'd0, c.threshold_high});
      write_register(CSR_THRESHOLD_LOW, {8'd0, c.threshold_low});
      write_register(CSR_CC_DEBOUNCE, c.cc_debounce_ticks);
      write_register(CSR_PD_DEBOUNCE, c.pd_debounce_ticks);
      write_register(CSR_SLEEP_DELAY, c.sleep_delay_ticks);
      write_register(CSR_SLEEP_ENABLE, {15'd0, c.sleep_enable});
      write_register(CSR_ATTACHED_CC_SENSE, {15'd0, c.attached_cc_sense});
      csr_write_enable <= 1'b0;
      model_cfg = c;
   endtask

   function automatic cfg_type random_config();
      int lo, hi;
      lo = $urandom_range(200, 1);
      hi = $urandom_range(255, lo + 1);
      case ($urandom_range(3))
         0: hi = 255;
         1: lo = 0;
         default: ;
      endcase
      return make_config(8'(hi), 8'(lo), 16'($urandom_range(6, 1)), 16'($urandom_range(4, 1)),
                         16'($urandom_range(6, 1)), $urandom_range(3) != 0,
                         $urandom_range(3) != 0);
   endfunction

   function automatic logic [7:0] pick_level(input logic [2:0] cls);
      int lo, hi;
      lo = model_cfg.threshold_low;
      hi = model_cfg.threshold_high;
      if (cls == CLS_OPEN) return 8'($urandom_range(255, hi));
      if (cls == CLS_RD && lo < hi) return 8'($urandom_range(hi - 1, lo));
      if (cls == CLS_RA && lo > 0 && hi > 0)
         return 8'($urandom_range(((lo < hi) ? lo : hi) - 1, 0));
      return 8'($urandom_range(255));
   endfunction

   function automatic logic [2:0] pick_class();
      case ($urandom_range(2))
         0: return CLS_RA;
         1: return CLS_RD;
         default: return CLS_OPEN;
      endcase
   endfunction

   task automatic test_reset_state();
      send_item(OP_TICK, 8'd0, 8'd255, 1'b0);
      send_item(OP_SAMPLE, 8'd128, 8'd7, 1'b0);
   endtask

   task automatic test_attach_detach_sleep();
      wait_for_responses();
      load_config(make_config(8'd200, 8'd100, 16'd3, 16'd2, 16'd2, 1'b1, 1'b1));
      send_item(OP_TICK, 8'd150, 8'd255, 1'b0);
      send_item(OP_SAMPLE, 8'd150, 8'd255, 1'b0);
      repeat (2) send_item(OP_TICK, 8'd150, 8'd255, 1'b0);
      repeat (2) send_item(OP_TICK, 8'd255, 8'd0, 1'b0);
      repeat (2) send_item(OP_TICK, 8'd255, 8'd255, 1'b0);
      send_item(OP_TICK, 8'd0, 8'd0, 1'b0);
      send_item(OP_SAMPLE, 8'd255, 8'd150, 1'b0);
      repeat (3) send_item(OP_TICK, 8'd255, 8'd150, 1'b0);
      repeat (2) send_item(OP_TICK, 8'd0, 8'd50, 1'b0);
      send_item(OP_TICK, 8'd0, 8'd150, 1'b0);
      send_item(OP_TICK, 8'd0, 8'd150, 1'b1);
   endtask

   task automatic test_forced_rd();
      wait_for_responses();
      load_config(make_config(8'd200, 8'd100, 16'd3, 16'd2, 16'd2, 1'b0, 1'b0));
      repeat (3) send_item(OP_TICK, 8'd150, 8'd50, 1'b0);
      send_item(OP_TICK, 8'd255, 8'd255, 1'b0);
   endtask

   task automatic test_countdown_extremes();
      wait_for_responses();
      load_config(make_config(8'd255, 8'd0, 16'd65535, 16'd0, 16'd65535, 1'b1, 1'b1));
      send_item(OP_TICK, 8'd255, 8'd0, 1'b1);
      send_item(OP_TICK, 8'd0, 8'd255, 1'b0);
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct);
      int         sent;
      logic [2:0] cls1, cls2;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (3) begin
         wait_for_responses();
         load_config(random_config());
         sent = 0;
         while (sent < 110) begin
            if ($urandom_range(99) < 20) begin
               send_item(1'($urandom_range(1)), 8'($urandom_range(255)),
                         8'($urandom_range(255)), 1'($urandom_range(1)));
               sent++;
            end else begin
               case ($urandom_range(5))
                  0: begin cls1 = CLS_RD;   cls2 = CLS_OPEN; end
                  1: begin cls1 = CLS_OPEN; cls2 = CLS_RD;   end
                  2: begin cls1 = CLS_RD;   cls2 = CLS_RA;   end
                  3: begin cls1 = CLS_RA;   cls2 = CLS_RD;   end
                  4: begin cls1 = CLS_OPEN; cls2 = CLS_OPEN; end
                  default: begin
                     cls1 = pick_class();
                     cls2 = pick_class();
                  end
               endcase
               repeat ($urandom_range(12, 1)) begin
                  send_item(($urandom_range(9) == 0) ? OP_SAMPLE : OP_TICK, pick_level(cls1),
                            pick_level(cls2), $urandom_range(19) == 0);
                  sent++;
               end
            end
         end
      end
   endtask

   task automatic test_backpressure();
      wait_for_responses();
      load_config(random_config());
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      rsp_holdoff_left = 200;
      repeat (60) send_item(OP_TICK, pick_level(pick_class()), pick_level(pick_class()),
                            $urandom_range(9) == 0);
      wait_for_responses();
      repeat (20) send_item(OP_TICK, pick_level(pick_class()), pick_level(pick_class()),
                            $urandom_range(9) == 0);
   endtask

   initial begin
      model_cfg = make_config(8'd0, 8'd0, CC_DEBOUNCE_RESET, PD_DEBOUNCE_RESET,
                              SLEEP_DELAY_RESET, 1'b0, 1'b1);
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_attach_detach_sleep();
      test_forced_rd();
      test_countdown_extremes();
      test_random_traffic(0, 0);
      test_random_traffic(63, 0);
      test_random_traffic(0, 63);
      test_random_traffic(26, 26);
      test_backpressure();
      wait_for_responses();
      if (error_count == 0) begin
         $display("typec_source_attach_detect_top_tb: PASS");
      end else begin
         $display("typec_source_attach_detect_top_tb: FAIL");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("typec_source_attach_detect_top_tb: FAIL");
      $finish;
   end

endmodule

/* files.f */
rtl/core/tcsad_pkg.sv
rtl/core/tcsad_classify.sv
rtl/core/tcsad_core.sv
rtl/core/typec_source_attach_detect_top.sv
test/typec_source_attach_detect_top_tb.sv
